// File: src/imad_pkg.sv
// Shared types, mode codes and the step size table of the IMA ADPCM nibble decoder.
package imad_pkg;

    // Mode codes carried in each input word.
    localparam logic [1:0] MODE_DECODE  = 2'd0;
    localparam logic [1:0] MODE_SAVE    = 2'd1;
    localparam logic [1:0] MODE_RESTORE = 2'd2;

    localparam logic [6:0] MAX_INDEX = 7'd88;
    localparam logic signed [17:0] SIG_MAX = 18'sd32767;
    localparam logic signed [17:0] SIG_MIN = -18'sd32768;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] code_nibble;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [6:0]         step_index;
    } out_word_t;

    // Architectural state of the decoder, including the loop point.
    typedef struct packed {
        logic signed [15:0] signal_acc;
        logic [6:0]         step_idx;
        logic signed [15:0] loop_signal;
        logic [6:0]         loop_step_idx;
        logic               loop_saved;
    } dec_state_t;

    // Standard IMA step size table; indexes past the end read the last entry.
    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        unique case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // Step index movement chosen by the three magnitude bits.
    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        unique case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

// File: src/imad_step.sv
// Next-state logic of the decoder for one input word: decode, loop save and loop restore.
module imad_step (
    input  logic [1:0]           mode,
    input  logic [3:0]           code_nibble,
    input  imad_pkg::dec_state_t cur,
    output imad_pkg::dec_state_t nxt
);

    logic [6:0]         idx_c;
    logic [14:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] sum;
    logic signed [15:0] sig_dec;
    logic signed [4:0]  adj;
    logic signed [7:0]  ni;
    logic [6:0]         idx_dec;

    // Decode datapath: table lookup, shift-add, saturate, index clamp.
    always_comb
    begin
        idx_c = (cur.step_idx > imad_pkg::MAX_INDEX) ? imad_pkg::MAX_INDEX : cur.step_idx;
        step  = imad_pkg::step_size(idx_c);
        diff  = {5'd0, step[14:3]};
        if (code_nibble[2])
        begin
            diff = diff + {2'd0, step};
        end
        if (code_nibble[1])
        begin
            diff = diff + {3'd0, step[14:1]};
        end
        if (code_nibble[0])
        begin
            diff = diff + {4'd0, step[14:2]};
        end

        if (code_nibble[3])
        begin
            sum = {{2{cur.signal_acc[15]}}, cur.signal_acc} - $signed({1'b0, diff});
        end
        else
        begin
            sum = {{2{cur.signal_acc[15]}}, cur.signal_acc} + $signed({1'b0, diff});
        end

        if (sum > imad_pkg::SIG_MAX)
        begin
            sig_dec = 16'sh7FFF;
        end
        else if (sum < imad_pkg::SIG_MIN)
        begin
            sig_dec = 16'sh8000;
        end
        else
        begin
            sig_dec = sum[15:0];
        end

        adj = imad_pkg::index_adjust(code_nibble[2:0]);
        ni  = $signed({1'b0, idx_c}) + {{3{adj[4]}}, adj};
        if (ni < 8'sd0)
        begin
            idx_dec = 7'd0;
        end
        else if (ni > $signed({1'b0, imad_pkg::MAX_INDEX}))
        begin
            idx_dec = imad_pkg::MAX_INDEX;
        end
        else
        begin
            idx_dec = ni[6:0];
        end
    end

    // Mode selection; the unused code leaves the state alone.
    always_comb
    begin
        nxt = cur;
        unique case (mode)
            imad_pkg::MODE_DECODE:
            begin
                nxt.signal_acc = sig_dec;
                nxt.step_idx   = idx_dec;
            end
            imad_pkg::MODE_SAVE:
            begin
                if (!cur.loop_saved)
                begin
                    nxt.loop_signal   = cur.signal_acc;
                    nxt.loop_step_idx = cur.step_idx;
                    nxt.loop_saved    = 1'b1;
                end
            end
            imad_pkg::MODE_RESTORE:
            begin
                nxt.signal_acc = cur.loop_signal;
                nxt.step_idx   = cur.loop_step_idx;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// File: src/ima_adpcm_nibble_decoder_top.sv
// Top level of the IMA ADPCM nibble decoder: input register, state update and result register.
//
//  Channel   Handshake                  Word        Contents
//  --------  -------------------------  ----------  ---------------------------------
//  code      code_valid / code_ready    code_word   mode, code_nibble
//  samp      samp_valid / samp_ready    samp_word   sample, step_index
//
// Each accepted word is held in the input register, then the decoder state
// and the result register are updated together from it, so the result is
// registered and a new word can be taken every cycle while the result
// register is free or being drained. The state update path (step table
// lookup, shift-add, saturation and index clamp) is the loop through the
// state register that sets the rate. An asynchronous low reset clears the
// accumulator, step index and loop point and empties both registers. When
// the result register is full and samp_ready is low, the input register
// holds its word and code_ready drops until the result is taken.
module ima_adpcm_nibble_decoder_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 code_valid,
    output logic                 code_ready,
    input  imad_pkg::in_word_t   code_word,
    output logic                 samp_valid,
    input  logic                 samp_ready,
    output imad_pkg::out_word_t  samp_word
);

    logic                 in_valid_reg;
    imad_pkg::in_word_t   in_word_reg;
    logic                 out_valid_reg;
    imad_pkg::out_word_t  out_word_reg;
    imad_pkg::dec_state_t state_reg;
    imad_pkg::dec_state_t state_next;
    logic                 advance;

    // The held word moves on whenever the result register is free or being drained.
    assign advance    = in_valid_reg && (!out_valid_reg || samp_ready);
    assign code_ready = !in_valid_reg || advance;

    imad_step u_step (
        .mode        (in_word_reg.mode),
        .code_nibble (in_word_reg.code_nibble),
        .cur         (state_reg),
        .nxt         (state_next)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (code_ready)
        begin
            in_valid_reg <= code_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_valid && code_ready)
        begin
            in_word_reg <= code_word;
        end
    end

    // Decoder state; it changes only when a word is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (samp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg.sample     <= state_next.signal_acc;
            out_word_reg.step_index <= state_next.step_idx;
        end
    end

    assign samp_valid = out_valid_reg;
    assign samp_word  = out_word_reg;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the IMA ADPCM nibble decoder with one-shot loop point.
`timescale 1ns / 100ps

module tb_top;

    // The package names three modes; the fourth code must leave the state alone.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Clamp limits of the decoder, kept as plain integers for the predictor.
    localparam int ACC_MAX   = 32767;
    localparam int ACC_MIN   = -32768;
    localparam int INDEX_TOP = 88;

    // Generous cycle limit.
    localparam int CYCLE_LIMIT = 1000000;

    // Receiver hold-offs: when they start, counted in accepted words, and how long.
    localparam int HOLD_AT_FIRST  = 300;
    localparam int HOLD_AT_SECOND = 1100;
    localparam int HOLD_CYCLES    = 400;

    localparam int RANDOM_WORDS = 1700;

    // A queued input word. A word marked for draining is only offered once
    // every result expected so far has come back.
    typedef struct {
        imad_pkg::in_word_t word;
        bit                 drain;
    } pending_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                code_valid = 1'b0;
    logic                code_ready;
    imad_pkg::in_word_t  code_word = '0;
    logic                samp_valid;
    logic                samp_ready = 1'b0;
    imad_pkg::out_word_t samp_word;

    pending_t            pending_words[$];
    imad_pkg::out_word_t expected_samples[$];

    // Standard IMA step sizes, one per step index.
    int step_table [0:88] = '{
        7, 8, 9, 10, 11, 12, 13, 14, 16, 17,
        19, 21, 23, 25, 28, 31, 34, 37, 41, 45,
        50, 55, 60, 66, 73, 80, 88, 97, 107, 118,
        130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
        337, 371, 408, 449, 494, 544, 598, 658, 724, 796,
        876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066,
        2272, 2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358,
        5894, 6484, 7132, 7845, 8630, 9493, 10442, 11487, 12635, 13899,
        15289, 16818, 18500, 20350, 22385, 24623, 27086, 29794, 32767
    };

    // Predictor state: the decoder's accumulator, step index and loop point.
    int pred_signal = 0;
    int pred_index = 0;
    int pred_loop_signal = 0;
    int pred_loop_index = 0;
    bit pred_loop_saved = 1'b0;

    int  total_words = 0;
    int  words_accepted = 0;
    int  samples_seen = 0;
    int  errors = 0;
    int  cycle_count = 0;
    bit  code_taken = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  holds_done = 0;

    ima_adpcm_nibble_decoder_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_word  (code_word),
        .samp_valid (samp_valid),
        .samp_ready (samp_ready),
        .samp_word  (samp_word)
    );

    always #10 clk = ~clk;

    // Step index movement: the four small magnitudes step down by one, the
    // four large ones step up by 2, 4, 6 or 8.
    function automatic int index_shift(input logic [2:0] mag);
        if (mag < 3'd4)
            return -1;
        return (int'(mag) - 3) * 2;
    endfunction

    // Advances the predicted decoder state by one word and returns the result
    // that the block should produce for it.
    function automatic imad_pkg::out_word_t predict_sample(input imad_pkg::in_word_t w);
        imad_pkg::out_word_t r;
        int                  step;
        int                  diff;
        int                  nxt;
        case (w.mode)
            imad_pkg::MODE_DECODE:
            begin
                step = step_table[(pred_index > INDEX_TOP) ? INDEX_TOP : pred_index];
                diff = step >> 3;
                if (w.code_nibble[2])
                    diff += step;
                if (w.code_nibble[1])
                    diff += step >> 1;
                if (w.code_nibble[0])
                    diff += step >> 2;
                if (w.code_nibble[3])
                    diff = -diff;
                nxt = pred_signal + diff;
                if (nxt > ACC_MAX)
                    nxt = ACC_MAX;
                else if (nxt < ACC_MIN)
                    nxt = ACC_MIN;
                pred_signal = nxt;
                nxt = pred_index + index_shift(w.code_nibble[2:0]);
                if (nxt > INDEX_TOP)
                    nxt = INDEX_TOP;
                else if (nxt < 0)
                    nxt = 0;
                pred_index = nxt;
            end
            imad_pkg::MODE_SAVE:
            begin
                // Only the first save after reset takes effect.
                if (!pred_loop_saved)
                begin
                    pred_loop_signal = pred_signal;
                    pred_loop_index  = pred_index;
                    pred_loop_saved  = 1'b1;
                end
            end
            imad_pkg::MODE_RESTORE:
            begin
                pred_signal = pred_loop_signal;
                pred_index  = pred_loop_index;
            end
            default:
            begin
                // The unused mode changes nothing.
            end
        endcase
        r.sample     = pred_signal[15:0];
        r.step_index = pred_index[6:0];
        return r;
    endfunction

    // Idle length between words or between takes: mostly none or short,
    // now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_word(input logic [1:0] mode, input logic [3:0] code, input bit drain);
        pending_t p;
        p.word.mode        = mode;
        p.word.code_nibble = code;
        p.drain            = drain;
        pending_words.push_back(p);
        total_words++;
    endtask

    // Stretches with no idling at all: the sender and the receiver each get
    // their own, at different points of the run.
    wire sender_calm   = ((words_accepted / 150) % 4) == 1;
    wire receiver_calm = ((samples_seen / 128) % 4) == 3;

    // Driver. Inputs change on the falling edge. A word stays on the bus with
    // valid high until the rising edge that accepts it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!code_valid || code_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    code_valid <= 1'b0;
                end
                else if (pending_words.size() > 0 &&
                         !(pending_words[0].drain && expected_samples.size() > 0))
                begin
                    code_word <= pending_words[0].word;
                    code_valid <= 1'b1;
                    void'(pending_words.pop_front());
                    gap_left <= sender_calm ? 0 : pick_gap();
                end
                else
                begin
                    code_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Random stalls, plus two long hold-offs counted here in cycles
    // while the sender keeps offering words, so the block fills and backs up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                samp_ready <= 1'b0;
            end
            else if ((holds_done == 0 && words_accepted >= HOLD_AT_FIRST) ||
                     (holds_done == 1 && words_accepted >= HOLD_AT_SECOND))
            begin
                hold_left <= HOLD_CYCLES;
                holds_done <= holds_done + 1;
                samp_ready <= 1'b0;
            end
            else if (receiver_calm)
            begin
                samp_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                samp_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                stall_left <= pick_gap();
                samp_ready <= 1'b0;
            end
            else
            begin
                samp_ready <= 1'b1;
            end
        end
    end

    // Monitor and predictor, both on the rising edge. The output side is
    // checked before the word accepted at this edge is predicted, so a result
    // can never be matched against an expectation it could not yet have.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samp_valid && samp_ready)
            begin
                samples_seen <= samples_seen + 1;
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected result, sample %0d step_index %0d",
                             $time, samp_word.sample, samp_word.step_index);
                    errors++;
                end
                else
                begin
                    if (samp_word.sample !== expected_samples[0].sample)
                    begin
                        $display("%0t: sample mismatch, expected %0d actual %0d",
                                 $time, expected_samples[0].sample, samp_word.sample);
                        errors++;
                    end
                    if (samp_word.step_index !== expected_samples[0].step_index)
                    begin
                        $display("%0t: step_index mismatch, expected %0d actual %0d",
                                 $time, expected_samples[0].step_index,
                                 samp_word.step_index);
                        errors++;
                    end
                    void'(expected_samples.pop_front());
                end
            end
            if (code_valid && code_ready)
            begin
                expected_samples.push_back(predict_sample(code_word));
                words_accepted <= words_accepted + 1;
            end
            code_taken <= code_valid && code_ready;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int seg_left;
        int bias;
        int roll;
        logic [1:0] mode;
        logic [3:0] code;

        // Directed words. Restore before any save and the unused mode come
        // first, while the state still holds its reset values.
        queue_word(MODE_UNUSED, 4'hF, 1'b0);
        queue_word(imad_pkg::MODE_RESTORE, 4'h0, 1'b0);
        // Every code once; the first four also push the index against zero.
        for (int c = 0; c < 16; c++)
            queue_word(imad_pkg::MODE_DECODE, c[3:0], 1'b0);
        // Large positive codes toward the top of the range.
        repeat (3) queue_word(imad_pkg::MODE_DECODE, 4'h7, 1'b0);
        queue_word(imad_pkg::MODE_SAVE, 4'h5, 1'b0);
        repeat (2) queue_word(imad_pkg::MODE_DECODE, 4'hF, 1'b0);
        // A second save must be ignored; restore brings back the first one.
        queue_word(imad_pkg::MODE_SAVE, 4'hA, 1'b0);
        queue_word(imad_pkg::MODE_RESTORE, 4'h3, 1'b0);

        // Random words in segments with a bias on the code, so that runs of
        // large codes drive the index to 88 and the accumulator into both
        // saturation limits, and runs of small codes walk the index back down.
        seg_left = 0;
        bias = 0;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(1, 40);
                bias = $urandom_range(0, 3);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            if (roll < 82)
                mode = imad_pkg::MODE_DECODE;
            else if (roll < 88)
                mode = imad_pkg::MODE_SAVE;
            else if (roll < 94)
                mode = imad_pkg::MODE_RESTORE;
            else
                mode = MODE_UNUSED;
            code = 4'($urandom_range(0, 15));
            case (bias)
                0: code[2] = 1'b1;
                1: code[2] = 1'b0;
                2: code[3] = 1'b0;
                default: code[3] = code[3];
            endcase
            // The sender waits for the block to empty before the random part
            // and once in the middle of it.
            queue_word(mode, code, (i == 0) || (i == RANDOM_WORDS / 2));
        end

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        while (words_accepted < total_words)
            @(posedge clk);
        while (expected_samples.size() > 0)
            @(posedge clk);
        // Keep running so that any extra result is caught.
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
